/* hdl/char_lcd_parallel_refresh_controller_unit_macros.svh */
// Assertion helpers used by the file that checks the LCD controller.
// Simulation gets the checks; synthesis sees empty bodies.
`ifndef CHAR_LCD_PARALLEL_REFRESH_CONTROLLER_UNIT_MACROS_SVH
`define CHAR_LCD_PARALLEL_REFRESH_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Implication in the same cycle.
`define CLCD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define CLCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CLCD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define CLCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* hdl/clcd_pkg.sv */
`timescale 1ns / 1ps

package clcd_pkg;

  localparam int LINE_CHARS = 16;
  localparam int STORE_SIZE = 2 * LINE_CHARS;
  localparam int STORE_AW   = $clog2(STORE_SIZE);
  localparam int INIT_BYTES = 6;
  // send_index runs up to 2*LINE_CHARS+2 during a refresh.
  localparam int SEND_W     = $clog2(2 * LINE_CHARS + 3);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_REFRESH = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POWERUP_DELAY   = 3'd0,
    REG_CONFIG_INTERVAL = 3'd1,
    REG_CONFIG_STROBE   = 3'd2,
    REG_DATA_STROBE     = 3'd3,
    REG_HOME_STROBE     = 3'd4,
    REG_DISPLAY_CONTROL = 3'd5,
    REG_LINE1_HOME      = 3'd6,
    REG_LINE2_HOME      = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] char_index;
    logic [7:0] char_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bus_data;
    logic       reg_select;
    logic       write_strobe;
    logic       ready_res;
  } out_item_t;

  typedef struct packed {
    logic [15:0] powerup_delay_ticks;
    logic [7:0]  config_interval_ticks;
    logic [7:0]  config_strobe_ticks;
    logic [7:0]  data_strobe_ticks;
    logic [7:0]  home_strobe_ticks;
    logic [7:0]  display_control_byte;
    logic [7:0]  line1_home_cmd;
    logic [7:0]  line2_home_cmd;
  } cfg_t;

  // Initialization command sequence; the third byte comes from a register.
  function automatic logic [7:0] init_byte(input logic [SEND_W-1:0] k,
                                           input logic [7:0] display_ctl);
    logic [7:0] b;
    case (k)
      SEND_W'(0): b = 8'h38;
      SEND_W'(1): b = 8'h38;
      SEND_W'(2): b = display_ctl;
      SEND_W'(3): b = 8'h06;
      SEND_W'(4): b = 8'h01;
      default:    b = 8'h02;
    endcase
    return b;
  endfunction

endpackage

/* hdl/clcd_ctrl.sv */
`timescale 1ns / 1ps

module clcd_ctrl import clcd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  in_item_t            item,
  input  cfg_t                cfg,
  input  logic [7:0]          store_rdata,
  output logic [STORE_AW-1:0] store_raddr,
  output out_item_t           result
);

  typedef enum logic [2:0] {
    PH_INIT,
    PH_CONFIG,
    PH_READY,
    PH_BUSY,
    PH_WRITE
  } phase_e;

  phase_e            phase_r, phase_nxt;
  logic [15:0]       tick_r, tick_nxt;
  logic [7:0]        strobe_cnt_r, strobe_cnt_nxt;
  logic [SEND_W-1:0] send_r, send_nxt;
  logic              pend_r, pend_nxt;
  logic [7:0]        bus_r, bus_nxt;
  logic              rs_r, rs_nxt;
  logic              stb_r, stb_nxt;

  // Second half of the frame sits one send slot later, after the line 2 home.
  assign store_raddr = (send_r < SEND_W'(LINE_CHARS)) ? STORE_AW'(send_r)
                                                      : STORE_AW'(send_r - SEND_W'(1));

  always_comb begin
    phase_nxt      = phase_r;
    tick_nxt       = tick_r;
    strobe_cnt_nxt = strobe_cnt_r;
    send_nxt       = send_r;
    pend_nxt       = pend_r;
    bus_nxt        = bus_r;
    rs_nxt         = rs_r;
    stb_nxt        = stb_r;
    if (step_en) begin
      // The item's own effect comes first.
      case (item.opcode)
        OP_TICK: begin
          if (tick_nxt != 16'hFFFF) tick_nxt = tick_nxt + 16'd1;
          if (strobe_cnt_nxt != 8'd0) strobe_cnt_nxt = strobe_cnt_nxt - 8'd1;
        end
        OP_REFRESH: pend_nxt = 1'b1;
        default: ;
      endcase
      // Then one controller step.
      unique case (phase_r)
        PH_INIT: begin
          if (tick_nxt >= cfg.powerup_delay_ticks) begin
            send_nxt       = '0;
            rs_nxt         = 1'b0;
            stb_nxt        = 1'b0;
            strobe_cnt_nxt = '0;
            tick_nxt       = '0;
            phase_nxt      = PH_CONFIG;
          end
        end
        PH_CONFIG: begin
          if (send_nxt < SEND_W'(INIT_BYTES) &&
              tick_nxt >= {8'd0, cfg.config_interval_ticks}) begin
            tick_nxt       = '0;
            bus_nxt        = init_byte(send_nxt, cfg.display_control_byte);
            rs_nxt         = 1'b0;
            stb_nxt        = 1'b1;
            strobe_cnt_nxt = cfg.config_strobe_ticks;
            send_nxt       = send_nxt + SEND_W'(1);
          end
          if (strobe_cnt_nxt == 8'd0) begin
            stb_nxt = 1'b0;
            if (send_nxt >= SEND_W'(INIT_BYTES)) begin
              send_nxt  = '0;
              pend_nxt  = 1'b0;
              phase_nxt = PH_READY;
            end
          end
        end
        PH_READY: begin
          if (pend_nxt) begin
            tick_nxt  = '0;
            phase_nxt = PH_BUSY;
          end
        end
        PH_BUSY: begin
          if (send_r == SEND_W'(LINE_CHARS)) begin
            bus_nxt        = cfg.line2_home_cmd;
            rs_nxt         = 1'b0;
            stb_nxt        = 1'b1;
            strobe_cnt_nxt = cfg.home_strobe_ticks;
            send_nxt       = send_r + SEND_W'(1);
            phase_nxt      = PH_WRITE;
          end else if (send_r == SEND_W'(2 * LINE_CHARS + 1)) begin
            bus_nxt        = cfg.line1_home_cmd;
            rs_nxt         = 1'b0;
            stb_nxt        = 1'b1;
            strobe_cnt_nxt = cfg.home_strobe_ticks;
            send_nxt       = send_r + SEND_W'(1);
            phase_nxt      = PH_WRITE;
          end else if (send_r >= SEND_W'(2 * LINE_CHARS + 2)) begin
            pend_nxt  = 1'b0;
            send_nxt  = '0;
            phase_nxt = PH_READY;
          end else begin
            bus_nxt        = store_rdata;
            rs_nxt         = 1'b1;
            stb_nxt        = 1'b1;
            strobe_cnt_nxt = cfg.data_strobe_ticks;
            send_nxt       = send_r + SEND_W'(1);
            phase_nxt      = PH_WRITE;
          end
        end
        default: begin
          if (strobe_cnt_nxt == 8'd0) begin
            stb_nxt   = 1'b0;
            phase_nxt = PH_BUSY;
          end
        end
      endcase
    end
  end

  assign result.bus_data     = bus_nxt;
  assign result.reg_select   = rs_nxt;
  assign result.write_strobe = stb_nxt;
  assign result.ready_res    = (phase_nxt == PH_READY) && !pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_INIT;
      tick_r       <= '0;
      strobe_cnt_r <= '0;
      send_r       <= '0;
      pend_r       <= 1'b0;
      bus_r        <= '0;
      rs_r         <= 1'b0;
      stb_r        <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      tick_r       <= tick_nxt;
      strobe_cnt_r <= strobe_cnt_nxt;
      send_r       <= send_nxt;
      pend_r       <= pend_nxt;
      bus_r        <= bus_nxt;
      rs_r         <= rs_nxt;
      stb_r        <= stb_nxt;
    end
  end

endmodule

/* hdl/char_lcd_parallel_refresh_controller_unit.sv */
`timescale 1ns / 1ps
// Refresh controller for a two-line character LCD on an 8-bit parallel bus.
// Input channel (in_valid / in_stall / in_item): each item is a timer tick,
// a character write into the 32-entry frame store, or a refresh request.
// Every accepted item first applies its own effect and then advances the
// controller by one step; exactly one result item follows it.
// Result channel (out_valid / out_stall / out_item): the bus byte, register
// select and write strobe levels to drive onto the LCD, plus a ready flag.
// The result of an item is captured in the output register at the edge that
// accepts the item and is offered from the next cycle on. Throughput is one
// item per cycle while the receiver does not stall, set by the single
// controller step between the input port and the output register.
// If the receiver stalls, the held result stays put and in_stall is raised
// until it is taken; an item is accepted again in the cycle it leaves.
// Configuration (cfg_we / cfg_index / cfg_wdata) writes a timing or command
// register; it is meant to be used while the block is idle.
// Synchronous reset loads the register defaults, fills the frame store with
// spaces and restarts the power-up wait; no clearing pass is needed.
`include "char_lcd_parallel_refresh_controller_unit_macros.svh"

module char_lcd_parallel_refresh_controller_unit import clcd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                cfg_r;
  logic [7:0]          store_r [STORE_SIZE];
  logic                out_valid_r;
  out_item_t           out_item_r;

  logic                in_accept;
  logic                store_we;
  logic [STORE_AW-1:0] store_waddr;
  logic [STORE_AW-1:0] store_raddr;
  logic [7:0]          store_rdata;
  out_item_t           step_result;

  // The output register frees up in the same cycle its result is taken.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign store_we    = in_accept && (in_item.opcode == OP_WRITE) &&
                       (int'(in_item.char_index) < STORE_SIZE);
  assign store_waddr = STORE_AW'(in_item.char_index);

  // A character written by this item is visible to the step it also takes.
  assign store_rdata = (store_we && store_waddr == store_raddr) ? in_item.char_value
                                                                : store_r[store_raddr];

  clcd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (in_accept),
    .item        (in_item),
    .cfg         (cfg_r),
    .store_rdata (store_rdata),
    .store_raddr (store_raddr),
    .result      (step_result)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.powerup_delay_ticks   <= 16'd500;
      cfg_r.config_interval_ticks <= 8'd60;
      cfg_r.config_strobe_ticks   <= 8'd30;
      cfg_r.data_strobe_ticks     <= 8'd1;
      cfg_r.home_strobe_ticks     <= 8'd2;
      cfg_r.display_control_byte  <= 8'h0C;
      cfg_r.line1_home_cmd        <= 8'h80;
      cfg_r.line2_home_cmd        <= 8'hC0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_POWERUP_DELAY:   cfg_r.powerup_delay_ticks   <= cfg_wdata;
        REG_CONFIG_INTERVAL: cfg_r.config_interval_ticks <= cfg_wdata[7:0];
        REG_CONFIG_STROBE:   cfg_r.config_strobe_ticks   <= cfg_wdata[7:0];
        REG_DATA_STROBE:     cfg_r.data_strobe_ticks     <= cfg_wdata[7:0];
        REG_HOME_STROBE:     cfg_r.home_strobe_ticks     <= cfg_wdata[7:0];
        REG_DISPLAY_CONTROL: cfg_r.display_control_byte  <= cfg_wdata[7:0];
        REG_LINE1_HOME:      cfg_r.line1_home_cmd        <= cfg_wdata[7:0];
        REG_LINE2_HOME:      cfg_r.line2_home_cmd        <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Frame store: flip-flops that reset to blank characters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_SIZE; i++) begin
        store_r[i] <= SPACE_CHAR;
      end
    end else if (store_we) begin
      store_r[store_waddr] <= in_item.char_value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_item_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Ready is only reported between transfers, with the bus on the command register.
  `CLCD_ASSERT_NOW(a_ready_idle_bus, clk, rst_n, out_valid_r && out_item_r.ready_res,
                   !out_item_r.write_strobe && !out_item_r.reg_select,
                   "ready reported while a byte is strobed or data is selected")
  // No item may overwrite a result that the receiver is still holding off.
  `CLCD_ASSERT_NOW(a_no_accept_over_held, clk, rst_n, out_valid_r && out_stall,
                   !in_accept, "item accepted while the held result is stalled")
  // A fresh result only appears after an accepted item.
  `CLCD_ASSERT_NEXT(a_result_from_item, clk, rst_n, !out_valid_r && !in_accept,
                    !out_valid_r, "result appeared without an accepted item")

endmodule
